[hw/rtl/sre_pkg.sv]
// ----------------------------------------------------------------------------
// sre_pkg
// Shared widths and constants of the signed Rice encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sre_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MAPPED_W    = 17;
  localparam int unsigned K_W         = 4;
  localparam int unsigned REM_W       = 15;
  localparam int unsigned CODE_W      = 16;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [K_W-1:0] K_RESET = 4'd2;

endpackage

`default_nettype wire

[hw/rtl/sre_front.sv]
// ----------------------------------------------------------------------------
// sre_front
// Holds the divisor exponent, maps each sample to an unsigned value and
// classifies its code as sendable or too long.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_front #(
  parameter int unsigned LIMIT = 1024,
  parameter int unsigned LEN_W = 11,
  parameter int unsigned ENTRY_W = 1 + sre_pkg::K_W + sre_pkg::REM_W + 2 * LEN_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [sre_pkg::K_W-1:0]      rice_k,
  input  wire logic                         in_valid,
  input  wire logic [sre_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                         queue_full,
  output logic                              push,
  output logic [ENTRY_W-1:0]                entry
);

  localparam int unsigned LW = sre_pkg::MAPPED_W + 1;

  logic [sre_pkg::K_W-1:0]      k_value;
  logic [sre_pkg::MAPPED_W-1:0] neg;
  logic [sre_pkg::MAPPED_W-1:0] mapped;
  logic [sre_pkg::MAPPED_W-1:0] quot;
  logic [LW-1:0]                len_full;
  logic                         too_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_value <= sre_pkg::K_RESET;
    end else if (cfg_valid) begin
      k_value <= rice_k;
    end
  end

  always_comb begin
    neg = sre_pkg::MAPPED_W'(0) - {sample[sre_pkg::SAMPLE_W-1], sample};
    if (sample[sre_pkg::SAMPLE_W-1] || (sample == '0)) begin
      mapped = {neg[sre_pkg::SAMPLE_W-1:0], 1'b0};
    end else begin
      mapped = {sample, 1'b0} - sre_pkg::MAPPED_W'(1);
    end
    quot     = mapped >> k_value;
    len_full = {1'b0, quot} + LW'(1) + LW'(k_value);
    too_long = len_full > LW'(LIMIT);
  end

  assign push  = in_valid && !queue_full;
  assign entry = {too_long, k_value, mapped[sre_pkg::REM_W-1:0],
                  quot[LEN_W-1:0], len_full[LEN_W-1:0]};

endmodule

`default_nettype wire

[hw/rtl/sre_queue.sv]
// ----------------------------------------------------------------------------
// sre_queue
// Small first-in first-out buffer between the classifier and the chunk
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

endmodule

`default_nettype wire

[hw/rtl/sre_back.sv]
// ----------------------------------------------------------------------------
// sre_back
// Cuts each queued code into chunks, one chunk per cycle while out_stall is
// low, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_back #(
  parameter int unsigned CHUNK_BITS = 16,
  parameter int unsigned LEN_W = 11,
  parameter int unsigned ENTRY_W = 1 + sre_pkg::K_W + sre_pkg::REM_W + 2 * LEN_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        head_valid,
  input  wire logic [ENTRY_W-1:0]          head,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [sre_pkg::CODE_W-1:0]       code_bits,
  output logic [sre_pkg::COUNT_W-1:0]      bit_count,
  output logic                             last_chunk,
  output logic                             overflow
);

  localparam int unsigned AW    = LEN_W + 2;
  localparam int unsigned CNT_W = $clog2(CHUNK_BITS + 1);

  logic                       e_ovf;
  logic [sre_pkg::K_W-1:0]    e_k;
  logic [sre_pkg::REM_W-1:0]  e_rem;
  logic [LEN_W-1:0]           e_q;
  logic [LEN_W-1:0]           e_len;

  logic [LEN_W-1:0]           pos;
  logic [LEN_W-1:0]           pos_next;
  logic [AW-1:0]              remaining;
  logic                       is_last;
  logic [AW-1:0]              n;
  logic [sre_pkg::CODE_W-1:0] chunk;
  logic                       load;
  logic                       take;

  assign {e_ovf, e_k, e_rem, e_q, e_len} = head;

  assign load = !out_valid || !out_stall;
  assign take = load && head_valid;

  always_comb begin
    logic [AW-1:0] idx;
    logic [AW-1:0] qk;
    logic [AW-1:0] sel;
    remaining = AW'(e_len) - AW'(pos);
    is_last   = e_ovf || (remaining <= AW'(CHUNK_BITS));
    n         = (remaining <= AW'(CHUNK_BITS)) ? remaining : AW'(CHUNK_BITS);
    qk        = AW'(e_q) + AW'(e_k);
    chunk     = '0;
    for (int b = 0; b < sre_pkg::CODE_W; b++) begin
      idx = AW'(pos) + n - AW'(1) - AW'(b);
      sel = qk - idx;
      if (AW'(b) < n) begin
        if (idx < AW'(e_q)) begin
          chunk[b] = 1'b1;
        end else if (idx == AW'(e_q)) begin
          chunk[b] = 1'b0;
        end else begin
          chunk[b] = e_rem[sel[sre_pkg::K_W-1:0]];
        end
      end
    end
    if (is_last) begin
      pos_next = '0;
    end else begin
      pos_next = LEN_W'(AW'(pos) + AW'(CHUNK_BITS));
    end
  end

  assign pop = take && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        pos <= pos_next;
      end
      if (load) begin
        out_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (e_ovf) begin
        code_bits  <= '0;
        bit_count  <= '0;
        last_chunk <= 1'b1;
        overflow   <= 1'b1;
      end else begin
        code_bits  <= chunk;
        bit_count  <= sre_pkg::COUNT_W'(n[CNT_W-1:0]);
        last_chunk <= is_last;
        overflow   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/signed_rice_encoder_core.sv]
// ----------------------------------------------------------------------------
// signed_rice_encoder_core
// Signed Golomb-Rice encoder with zigzag mapping; emits each code in chunks.
// ----------------------------------------------------------------------------
//  Channel   Signals                                       Direction
//  config    cfg_valid, cfg_ready, rice_k                  in
//  sample    in_valid, in_stall, sample                    in
//  chunk     out_valid, out_stall, code_bits, bit_count,   out
//            last_chunk, overflow
//
// A sample is classified in the cycle of its transfer and queued in a
// two-entry buffer. The chunk generator sends one chunk per cycle while
// out_stall is low, ceil(length / CHUNK_BITS) chunks per sample and a single
// chunk for a refused code. Reset is synchronous and sets rice_k to 2. The
// input stalls only while the buffer is full.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_rice_encoder_core #(
  parameter int unsigned CHUNK_BITS    = 16,
  parameter int unsigned MAX_CODE_BITS = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [sre_pkg::K_W-1:0]      rice_k,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sre_pkg::SAMPLE_W-1:0] sample,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [sre_pkg::CODE_W-1:0]        code_bits,
  output logic [sre_pkg::COUNT_W-1:0]       bit_count,
  output logic                              last_chunk,
  output logic                              overflow
);

  localparam int unsigned CHUNK_LIMIT = sre_pkg::MAX_RESULTS * CHUNK_BITS;
  localparam int unsigned LIMIT =
    (MAX_CODE_BITS < CHUNK_LIMIT) ? MAX_CODE_BITS : CHUNK_LIMIT;
  localparam int unsigned LEN_W   = $clog2(LIMIT + 1);
  localparam int unsigned ENTRY_W = 1 + sre_pkg::K_W + sre_pkg::REM_W + 2 * LEN_W;

  logic               push;
  logic               pop;
  logic               full;
  logic               not_empty;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] head;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;

  sre_front #(
    .LIMIT   (LIMIT),
    .LEN_W   (LEN_W),
    .ENTRY_W (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .rice_k     (rice_k),
    .in_valid   (in_valid),
    .sample     (sample),
    .queue_full (full),
    .push       (push),
    .entry      (entry)
  );

  sre_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (sre_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  sre_back #(
    .CHUNK_BITS (CHUNK_BITS),
    .LEN_W      (LEN_W),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_bits  (code_bits),
    .bit_count  (bit_count),
    .last_chunk (last_chunk),
    .overflow   (overflow)
  );

endmodule

`default_nettype wire

[verif/tb_signed_rice_encoder_core.sv]
// ----------------------------------------------------------------------------
// tb_signed_rice_encoder_core
// Self-checking testbench for the signed Rice encoder. Every sample transfer
// is encoded by a local predictor into its expected chunks. Each chunk
// transfer is compared field by field with the oldest expected chunk. The
// divisor setting is changed between phases while the encoder is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_signed_rice_encoder_core;

  localparam int CHUNK_BITS     = 16;
  localparam int MAX_CODE_BITS  = 1024;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int ITEMS_PER_K    = 36;

  typedef struct {
    logic [sre_pkg::CODE_W-1:0]  bits;
    logic [sre_pkg::COUNT_W-1:0] count;
    logic                        last;
    logic                        ovf;
  } chunk_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sre_pkg::K_W-1:0]       rice_k = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [sre_pkg::SAMPLE_W-1:0]  sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [sre_pkg::CODE_W-1:0]    code_bits;
  logic [sre_pkg::COUNT_W-1:0]   bit_count;
  logic                          last_chunk;
  logic                          overflow;

  logic [sre_pkg::SAMPLE_W-1:0]  pending_samples[$];
  chunk_t                        expected_chunks[$];
  logic [sre_pkg::K_W-1:0]       k_setting = sre_pkg::K_RESET;
  int                            error_count = 0;
  int                            idle_cycles = 0;
  int                            burst_left = 1;
  int                            gap_left = 0;
  int                            stall_phase = 0;
  stall_mode_t                   stall_mode = STALL_NONE;

  int                            cases_k2[$] = '{0, 1, -1, 2, -2, 32767, -32768,
                                                 2044, 2045, -2043, -2044};
  int                            cases_k0[$] = '{0, 1, -1, 512, -512};
  int                            cases_k15[$] = '{32767, -32768, 0};
  int                            k_plan[$] = '{0, 15, 1, 6, 3, 11, 0, 9};

  signed_rice_encoder_core #(
    .CHUNK_BITS    (CHUNK_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .rice_k     (rice_k),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_bits  (code_bits),
    .bit_count  (bit_count),
    .last_chunk (last_chunk),
    .overflow   (overflow)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Zigzag map, split into quotient and remainder, and cut the code into chunks.
  function automatic void rice_encode(input logic signed [15:0] x,
                                      input logic [3:0] k);
    int     xv;
    int     u;
    int     q;
    int     len;
    int     pos;
    int     cnt;
    logic   b;
    chunk_t c;
    logic [15:0] acc;
    xv = x;
    u = (xv <= 0) ? -2 * xv : 2 * xv - 1;
    q = u >> k;
    len = q + 1 + k;
    if (len > MAX_CODE_BITS || (len + CHUNK_BITS - 1) / CHUNK_BITS > sre_pkg::MAX_RESULTS) begin
      c.bits = '0;
      c.count = '0;
      c.last = 1'b1;
      c.ovf = 1'b1;
      expected_chunks.push_back(c);
      return;
    end
    acc = '0;
    cnt = 0;
    for (int i = 0; i < len; i++) begin
      if (i < q) begin
        b = 1'b1;
      end else if (i == q) begin
        b = 1'b0;
      end else begin
        pos = k - 1 - (i - q - 1);
        b = u[pos];
      end
      acc = {acc[14:0], b};
      cnt++;
      if (cnt == CHUNK_BITS || i + 1 == len) begin
        c.bits = acc;
        c.count = 5'(cnt);
        c.last = (i + 1 == len);
        c.ovf = 1'b0;
        expected_chunks.push_back(c);
        acc = '0;
        cnt = 0;
      end
    end
  endfunction

  // Mostly codes that fit, split between short ones and ones up to the length
  // limit, with fully random samples mixed in.
  function automatic logic [15:0] pick_sample(input logic [3:0] k);
    int r;
    int lim;
    int mag;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      return 16'($urandom);
    end
    if (r < 55) begin
      lim = (16 << k) / 2;
    end else begin
      lim = ((1023 - k) << k) / 2 + 1;
    end
    if (lim > 32767) begin
      lim = 32767;
    end
    mag = $urandom_range(0, lim);
    return ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic write_rice_k(input logic [3:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    rice_k <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    k_setting = val;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_chunks.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_valid <= 1'b1;
        sample <= pending_samples.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_phase++;
      if (stall_phase % 60 == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
      end
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        STALL_HEAVY: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= (stall_phase % 3 != 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    chunk_t want;
    logic   progress;
    if (!rst) begin
      progress = cfg_valid && cfg_ready;
      if (in_valid && !in_stall) begin
        rice_encode(sample, k_setting);
        progress = 1'b1;
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        if (expected_chunks.size() == 0) begin
          report_mismatch($sformatf("unexpected chunk bits=%h count=%0d", code_bits,
                                    bit_count));
        end else begin
          want = expected_chunks.pop_front();
          if (code_bits !== want.bits) begin
            report_mismatch($sformatf("code_bits %h, expected %h", code_bits, want.bits));
          end
          if (bit_count !== want.count) begin
            report_mismatch($sformatf("bit_count %0d, expected %0d", bit_count,
                                      want.count));
          end
          if (last_chunk !== want.last) begin
            report_mismatch($sformatf("last_chunk %b, expected %b", last_chunk,
                                      want.last));
          end
          if (overflow !== want.ovf) begin
            report_mismatch($sformatf("overflow %b, expected %b", overflow, want.ovf));
          end
        end
      end
      if (progress) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("signed_rice_encoder_core: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    foreach (cases_k2[i]) pending_samples.push_back(16'(cases_k2[i]));
    wait_drained();

    write_rice_k(4'd0);
    @(negedge clk);
    foreach (cases_k0[i]) pending_samples.push_back(16'(cases_k0[i]));
    wait_drained();

    write_rice_k(4'd15);
    @(negedge clk);
    foreach (cases_k15[i]) pending_samples.push_back(16'(cases_k15[i]));
    wait_drained();

    foreach (k_plan[p]) begin
      write_rice_k((p == 6) ? 4'($urandom_range(0, 15)) : 4'(k_plan[p]));
      @(negedge clk);
      repeat (ITEMS_PER_K) pending_samples.push_back(pick_sample(k_setting));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_chunks.size() == 0) begin
      $display("signed_rice_encoder_core: match");
    end else begin
      $display("signed_rice_encoder_core: mismatch");
    end
    $finish;
  end

endmodule

[signed_rice_encoder_core.f]
hw/rtl/sre_pkg.sv
hw/rtl/sre_front.sv
hw/rtl/sre_queue.sv
hw/rtl/sre_back.sv
hw/rtl/signed_rice_encoder_core.sv
verif/tb_signed_rice_encoder_core.sv
